// ===== hw/rtl/bfd_pkg.sv =====
package bfd_pkg;

  // Geometry of the file
  localparam int          PV_BYTES_DEF = 96;
  localparam int          HDR_LEN      = 24;
  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
  localparam logic [39:0] LEN_MAX      = 40'hFF_FFFF_FFFF;

  // Configuration registers
  localparam int          CFG_ADDR_W     = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_FORMAT_VER = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_ENGINE_VER = 1'b1;
  localparam logic [31:0] FORMAT_VER_RST = 32'd2;
  localparam logic [31:0] ENGINE_VER_RST = 32'd1;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SHORT   = 3'd1;
  localparam logic [2:0] ST_VERSION = 3'd2;
  localparam logic [2:0] ST_SIZE    = 3'd3;
  localparam logic [2:0] ST_CRC     = 3'd4;

  // Result kinds
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Which record field a body byte lands in
  localparam logic [1:0] FLD_NONE = 2'd0;
  localparam logic [1:0] FLD_KEY  = 2'd1;
  localparam logic [1:0] FLD_INFO = 2'd2;

  // One classified byte, front to back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       hdr;      // header byte
    logic [4:0] pos;      // header position, or byte lane within a field
    logic [1:0] fld;
    logic       rec_end;  // last byte of a record
  } bfd_op_t;

  // One result item
  typedef struct packed {
    logic               kind;
    logic [63:0]        key;
    logic signed [31:0] score;
    logic signed [15:0] mate;
    logic signed [15:0] depth;
    logic [2:0]         status;
    logic               final_res;
  } bfd_res_t;

  // Up to two results per classified byte
  typedef struct packed {
    logic [1:0] n;
    bfd_res_t   item0;
    bfd_res_t   item1;
  } bfd_push_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h47;
      2'd1:    b = 8'h4D;
      2'd2:    b = 8'h42;
      default: b = 8'h4B;
    endcase
    return b;
  endfunction

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/bfd_ifs.sv =====
interface bfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;
  modport source(output valid, data_byte, end_of_file, input ready);
  modport sink(input valid, data_byte, end_of_file, output ready);
endinterface

interface bfd_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [63:0]        record_key;
  logic signed [31:0] record_score;
  logic signed [15:0] record_mate;
  logic signed [15:0] record_depth;
  logic [2:0]         status;
  logic               final_res;
  modport source(output valid, kind, record_key, record_score, record_mate, record_depth,
                 status, final_res, input ready);
  modport sink(input valid, kind, record_key, record_score, record_mate, record_depth,
               status, final_res, output ready);
endinterface

interface bfd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bfd_pkg::CFG_ADDR_W-1:0]  addr;
  logic [31:0]                     data;
  modport source(output valid, addr, data, input ready);
  modport sink(input valid, addr, data, output ready);
endinterface

// ===== hw/rtl/book_file_record_deframer.sv =====
// Book file record deframer.
// in_ch takes the file one byte per item; end_of_file marks the last byte.
// out_ch gives a record item (kind 0: key, score, mate, depth) when the last
// byte of each body record arrives, and a status item (kind 1, final_res 1)
// after the final byte. Drop the records of a run whose status is not ok.
// cfg_ch writes the expected format (index 0) and engine (index 1) words;
// it is always ready and should be written between files.
// Throughput: one byte per cycle while the output queue has room; set by the
// one-byte CRC step in the back end. A byte that closes a record and the
// file pushes two items, which the receiver takes one after the other.
// Reset: counters clear, the CRC presets to all ones, the expected words go
// to 2 and 1, and both queues empty.
// Receiver stall: results wait in a four-entry output queue; once it holds
// more than two the back end stops, the two-entry byte queue fills, and
// in_ch.ready drops. No item is lost or repeated.
module book_file_record_deframer #(
  parameter int PV_BYTES = bfd_pkg::PV_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bfd_in_if.sink    in_ch,
  bfd_out_if.source out_ch,
  bfd_cfg_if.sink   cfg_ch
);
  import bfd_pkg::*;

  logic      op_valid;
  logic      op_pop;
  bfd_op_t   op;
  logic      room;
  bfd_push_t push;

  bfd_front #(.PV_BYTES(PV_BYTES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .op_pop   (op_pop),
    .op_valid (op_valid),
    .op       (op)
  );

  bfd_back #(.PV_BYTES(PV_BYTES)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_ch   (cfg_ch),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop),
    .room     (room),
    .push     (push)
  );

  bfd_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

// ===== hw/rtl/bfd_front.sv =====
module bfd_front #(
  parameter int PV_BYTES = bfd_pkg::PV_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  bfd_in_if.sink           in_ch,
  input  logic             op_pop,
  output logic             op_valid,
  output bfd_pkg::bfd_op_t op
);
  import bfd_pkg::*;

  localparam int REC_LEN = 16 + PV_BYTES;
  // Wide enough to hold the record length itself, so the field bounds fit
  localparam int OFF_W   = $clog2(REC_LEN + 1);

  logic [4:0]       hp_r;
  logic [OFF_W-1:0] off_r;
  logic             accept;
  bfd_op_t          op_new;

  bfd_op_t          q_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign accept      = in_ch.valid && in_ch.ready;
  assign op_valid    = (cnt_r != 2'd0);
  assign op          = q_r[rd_ptr_r];

  // Classify the incoming byte
  always_comb begin
    op_new.data    = in_ch.data_byte;
    op_new.last    = in_ch.end_of_file;
    op_new.hdr     = (hp_r != 5'(HDR_LEN));
    op_new.rec_end = (off_r == OFF_W'(REC_LEN - 1));
    if (op_new.hdr) begin
      op_new.pos = hp_r;
      op_new.fld = FLD_NONE;
    end else begin
      op_new.pos = {2'd0, off_r[2:0]};
      if (off_r < OFF_W'(8))       op_new.fld = FLD_KEY;
      else if (off_r < OFF_W'(16)) op_new.fld = FLD_INFO;
      else                         op_new.fld = FLD_NONE;
    end
  end

  // Header and record position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r  <= '0;
      off_r <= '0;
    end else if (accept) begin
      if (in_ch.end_of_file) begin
        hp_r  <= '0;
        off_r <= '0;
      end else if (op_new.hdr) begin
        hp_r <= hp_r + 5'd1;
      end else if (op_new.rec_end) begin
        off_r <= '0;
      end else begin
        off_r <= off_r + OFF_W'(1);
      end
    end
  end

  // Two-entry queue toward the back end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (accept) wr_ptr_r <= ~wr_ptr_r;
      if (op_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(accept) - 2'(op_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) q_r[wr_ptr_r] <= op_new;
  end

endmodule

// ===== hw/rtl/bfd_back.sv =====
module bfd_back #(
  parameter int PV_BYTES = bfd_pkg::PV_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  bfd_cfg_if.sink            cfg_ch,
  input  logic               op_valid,
  input  bfd_pkg::bfd_op_t   op,
  output logic               op_pop,
  input  logic               room,
  output bfd_pkg::bfd_push_t push
);
  import bfd_pkg::*;

  localparam int REC_LEN = 16 + PV_BYTES;

  logic [31:0] fmt_r, eng_r;

  logic        fault_r, fault_nxt;
  logic [63:0] ver_r, ver_nxt;
  logic [31:0] count_r, count_nxt;
  logic [31:0] stored_r, stored_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [39:0] len_r, len_nxt;
  logic [63:0] key_r, key_nxt;
  logic [63:0] info_r, info_nxt;
  logic [40:0] want_r;
  logic [2:0]  ver_idx;
  logic        go;
  logic        short_file;
  logic        emit_rec;
  logic [2:0]  st;
  bfd_res_t    rec_item, st_item;

  // Configuration writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FORMAT_VER_RST;
      eng_r <= ENGINE_VER_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        REG_FORMAT_VER: fmt_r <= cfg_ch.data;
        REG_ENGINE_VER: eng_r <= cfg_ch.data;
      endcase
    end
  end

  // Take an item only when the result queue can hold two more
  assign go     = op_valid && room;
  assign op_pop = go;

  assign ver_idx = 3'(op.pos - 5'd4);

  // Header capture, CRC, length and field assembly
  always_comb begin
    fault_nxt  = fault_r;
    ver_nxt    = ver_r;
    count_nxt  = count_r;
    stored_nxt = stored_r;
    crc_nxt    = crc_r;
    len_nxt    = len_r;
    key_nxt    = key_r;
    info_nxt   = info_r;
    if (go) begin
      if (op.hdr) begin
        if (op.pos < 5'd4) begin
          if (op.data != magic_byte(op.pos[1:0])) fault_nxt = 1'b1;
        end else if (op.pos < 5'd12) begin
          ver_nxt[{ver_idx, 3'b000} +: 8] = op.data;
        end else if (op.pos < 5'd16) begin
          count_nxt[{op.pos[1:0], 3'b000} +: 8] = op.data;
        end else if (op.pos < 5'd20) begin
          stored_nxt[{op.pos[1:0], 3'b000} +: 8] = op.data;
        end
      end else begin
        crc_nxt = crc_byte(crc_r, op.data);
        if (len_r != LEN_MAX) len_nxt = len_r + 40'd1;
        case (op.fld)
          FLD_KEY:  key_nxt[{op.pos[2:0], 3'b000} +: 8] = op.data;
          FLD_INFO: info_nxt[{op.pos[2:0], 3'b000} +: 8] = op.data;
          default:  ;
        endcase
      end
    end
  end

  // Final status, checks in precedence order
  assign short_file = op.hdr && (op.pos != 5'(HDR_LEN - 1));

  always_comb begin
    if (short_file || fault_nxt)                                st = ST_SHORT;
    else if (ver_r[31:0] != fmt_r || ver_r[63:32] != eng_r)     st = ST_VERSION;
    else if (len_nxt == LEN_MAX || {1'b0, len_nxt} != want_r)   st = ST_SIZE;
    else if ((crc_nxt ^ ALL_ONES) != stored_r)                  st = ST_CRC;
    else                                                        st = ST_OK;
  end

  assign emit_rec = !op.hdr && op.rec_end;

  always_comb begin
    rec_item.kind      = KIND_RECORD;
    rec_item.key       = key_nxt;
    rec_item.score     = info_nxt[31:0];
    rec_item.mate      = info_nxt[47:32];
    rec_item.depth     = info_nxt[63:48];
    rec_item.status    = ST_OK;
    rec_item.final_res = 1'b0;

    st_item.kind      = KIND_STATUS;
    st_item.key       = '0;
    st_item.score     = '0;
    st_item.mate      = '0;
    st_item.depth     = '0;
    st_item.status    = st;
    st_item.final_res = 1'b1;

    push.n     = go ? (2'(emit_rec) + 2'(op.last)) : 2'd0;
    push.item0 = emit_rec ? rec_item : st_item;
    push.item1 = st_item;
  end

  // Run state, cleared after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r <= 1'b0;
      crc_r   <= ALL_ONES;
      len_r   <= '0;
    end else if (go && op.last) begin
      fault_r <= 1'b0;
      crc_r   <= ALL_ONES;
      len_r   <= '0;
    end else begin
      fault_r <= fault_nxt;
      crc_r   <= crc_nxt;
      len_r   <= len_nxt;
    end
  end

  // Header words and record fields; all rewritten before use
  always_ff @(posedge clk) begin
    ver_r    <= ver_nxt;
    count_r  <= count_nxt;
    stored_r <= stored_nxt;
    key_r    <= key_nxt;
    info_r   <= info_nxt;
    want_r   <= 41'(count_r) * 41'(REC_LEN);
  end

endmodule

// ===== hw/rtl/bfd_outq.sv =====
module bfd_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  bfd_pkg::bfd_push_t push,
  output logic               room,
  bfd_out_if.source          out_ch
);
  import bfd_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  bfd_res_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pop;
  bfd_res_t         head;

  assign head         = mem_r[rd_ptr_r];
  assign out_ch.valid = (cnt_r != '0);
  assign pop          = out_ch.valid && out_ch.ready;
  assign room         = (cnt_r <= CNT_W'(DEPTH - 2));

  assign out_ch.kind         = head.kind;
  assign out_ch.record_key   = head.key;
  assign out_ch.record_score = head.score;
  assign out_ch.record_mate  = head.mate;
  assign out_ch.record_depth = head.depth;
  assign out_ch.status       = head.status;
  assign out_ch.final_res    = head.final_res;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push.n);
      if (pop) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      cnt_r <= cnt_r + CNT_W'(push.n) - CNT_W'(pop);
    end
  end

  // Up to two writes per cycle
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wr_ptr_r] <= push.item0;
    if (push.n == 2'd2) mem_r[wr_ptr_r + PTR_W'(1)] <= push.item1;
  end

endmodule

// ===== hw/rtl/bfd_checker.sv =====
module bfd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_kind,
  input logic [63:0]        out_key,
  input logic signed [31:0] out_score,
  input logic signed [15:0] out_mate,
  input logic signed [15:0] out_depth,
  input logic [2:0]         out_status,
  input logic               out_final
);
  import bfd_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_kind, out_key, out_score, out_mate, out_depth, out_status, out_final}))
    else $error("result changed while stalled");

  // Status items carry a legal code, the final flag and empty record fields
  a_status_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_STATUS |-> out_final && out_status <= ST_CRC &&
      out_key == '0 && out_score == '0 && out_mate == '0 && out_depth == '0)
    else $error("malformed status item");

  // Record items never carry status
  a_record_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_RECORD |-> !out_final && out_status == ST_OK)
    else $error("malformed record item");

endmodule

bind book_file_record_deframer bfd_checker u_bfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_kind   (out_ch.kind),
  .out_key    (out_ch.record_key),
  .out_score  (out_ch.record_score),
  .out_mate   (out_ch.record_mate),
  .out_depth  (out_ch.record_depth),
  .out_status (out_ch.status),
  .out_final  (out_ch.final_res)
);

// ===== dv/tb_book_file_record_deframer.sv =====
module tb_book_file_record_deframer;
  import bfd_pkg::*;

  localparam int          REC_BYTES   = 16 + PV_BYTES_DEF;
  localparam int          DRAIN_TAIL  = 8;
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          RAND_BYTES  = 200;
  localparam logic [31:0] MAGIC_WORD  = 32'h4B42_4D47;  // first byte in the low lane

  typedef logic [7:0] byte_q_t [$];

  // How a generated book file is shaped
  typedef enum int {
    BOOK_GOOD,
    BOOK_BAD_MAGIC,
    BOOK_BAD_FORMAT,
    BOOK_BAD_ENGINE,
    BOOK_BAD_COUNT,
    BOOK_BAD_CRC,
    BOOK_PARTIAL,
    BOOK_TRUNCATED,
    BOOK_NOISE
  } book_shape_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bfd_in_if  in_ch();
  bfd_out_if out_ch();
  bfd_cfg_if cfg_ch();

  book_file_record_deframer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Deframer state as the block should hold it
  int          hdr_seen;
  logic        magic_bad;
  logic [63:0] ver_words;
  logic [31:0] decl_count;
  logic [31:0] stored_crc;
  logic [31:0] run_crc;
  logic [39:0] body_len;
  int          rec_off;
  logic [63:0] rec_key;
  logic [63:0] rec_info;   // score, mate, depth packed low to high
  logic [31:0] fmt_reg;
  logic [31:0] eng_reg;

  bfd_res_t book_items_due [$];

  int failures     = 0;
  int bytes_sent   = 0;
  bit calm         = 1'b0;  // no idling on either side

  function automatic void clear_book_state();
    hdr_seen   = 0;
    magic_bad  = 1'b0;
    ver_words  = '0;
    decl_count = '0;
    stored_crc = '0;
    run_crc    = ALL_ONES;
    body_len   = '0;
    rec_off    = 0;
    rec_key    = '0;
    rec_info   = '0;
  endfunction

  // Reflected CRC-32, one data bit per shift
  function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ ((r[0] ^ b[i]) ? CRC_POLY : 32'h0);
    end
    return r;
  endfunction

  // Advance the deframer by one byte and queue whatever it produces
  function automatic void deframe_byte(input logic [7:0] b, input logic eof);
    bfd_res_t    r;
    logic [63:0] want_len;
    if (hdr_seen < HDR_LEN) begin
      if (hdr_seen < 4) begin
        if (b != MAGIC_WORD[8*hdr_seen +: 8]) magic_bad = 1'b1;
      end else if (hdr_seen < 12) begin
        ver_words[8*(hdr_seen-4) +: 8] = b;
      end else if (hdr_seen < 16) begin
        decl_count[8*(hdr_seen-12) +: 8] = b;
      end else if (hdr_seen < 20) begin
        stored_crc[8*(hdr_seen-16) +: 8] = b;
      end
      hdr_seen++;
    end else begin
      run_crc = crc32_update(run_crc, b);
      if (body_len != LEN_MAX) body_len++;
      if (rec_off < 8) begin
        rec_key[8*rec_off +: 8] = b;
      end else if (rec_off < 16) begin
        rec_info[8*(rec_off-8) +: 8] = b;
      end
      if (rec_off + 1 >= REC_BYTES) begin
        r       = '0;
        r.kind  = KIND_RECORD;
        r.key   = rec_key;
        r.score = rec_info[31:0];
        r.mate  = rec_info[47:32];
        r.depth = rec_info[63:48];
        book_items_due = {book_items_due, r};
        rec_off = 0;
      end else begin
        rec_off++;
      end
    end
    // Status, in order of precedence
    if (eof) begin
      r           = '0;
      r.kind      = KIND_STATUS;
      r.final_res = 1'b1;
      want_len    = 64'(decl_count) * 64'(REC_BYTES);
      if (hdr_seen < HDR_LEN || magic_bad) begin
        r.status = ST_SHORT;
      end else if (ver_words[31:0] != fmt_reg || ver_words[63:32] != eng_reg) begin
        r.status = ST_VERSION;
      end else if (body_len == LEN_MAX || 64'(body_len) != want_len) begin
        r.status = ST_SIZE;
      end else if (~run_crc != stored_crc) begin
        r.status = ST_CRC;
      end else begin
        r.status = ST_OK;
      end
      book_items_due = {book_items_due, r};
      clear_book_state();
    end
  endfunction

  function automatic int pick_wait();
    if (calm) return 0;
    return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 14) : 0;
  endfunction

  // Body bytes lean toward sign boundaries
  function automatic logic [7:0] record_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_version();
    case ($urandom_range(0, 3))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  function automatic void put_word(ref byte_q_t f, input logic [31:0] w);
    for (int k = 0; k < 4; k++) f = {f, w[8*k +: 8]};
  endfunction

  // Build a book file against the current register values.
  // head0 overrides the first 16 bytes of the first record: {depth, mate, score, key}.
  function automatic void make_book(output byte_q_t f, input book_shape_t shape,
                                    input int n_rec, input logic [127:0] head0,
                                    input bit use_head);
    byte_q_t     body;
    logic [31:0] crc;
    logic [31:0] fmt;
    logic [31:0] eng;
    logic [31:0] cnt;
    int          cut;
    f = {};
    if (shape == BOOK_NOISE) begin
      repeat ($urandom_range(1, 60)) f = {f, 8'($urandom)};
      return;
    end
    for (int i = 0; i < n_rec * REC_BYTES; i++) body = {body, record_byte()};
    if (use_head) begin
      for (int k = 0; k < 16; k++) body[k] = head0[8*k +: 8];
    end
    if (shape == BOOK_PARTIAL) begin
      repeat ($urandom_range(1, REC_BYTES - 1)) body = {body, record_byte()};
    end
    crc = ALL_ONES;
    foreach (body[i]) crc = crc32_update(crc, body[i]);
    crc = ~crc;
    fmt = fmt_reg;
    eng = eng_reg;
    cnt = n_rec;
    case (shape)
      BOOK_BAD_FORMAT: fmt = fmt ^ ($urandom | 32'd1);
      BOOK_BAD_ENGINE: eng = eng ^ ($urandom | 32'd1);
      BOOK_BAD_COUNT:  cnt = ($urandom_range(0, 1) == 0) ? cnt + $urandom_range(1, 3) : $urandom;
      BOOK_BAD_CRC:    crc = crc ^ (32'd1 << $urandom_range(0, 31));
      default: ;
    endcase
    put_word(f, MAGIC_WORD);
    if (shape == BOOK_BAD_MAGIC) begin
      cut    = $urandom_range(0, 3);
      f[cut] = f[cut] ^ 8'($urandom_range(1, 255));
    end
    put_word(f, fmt);
    put_word(f, eng);
    put_word(f, cnt);
    put_word(f, crc);
    put_word(f, $urandom);  // reserved lane, ignored
    foreach (body[i]) f = {f, body[i]};
    if (shape == BOOK_TRUNCATED) begin
      cut = $urandom_range(1, HDR_LEN - 1);
      while (f.size() > cut) void'(f.pop_back());
    end
  endfunction

  // Offer one byte; returns at the falling edge after it was taken.
  // valid stays high so back-to-back bytes need no extra assignment.
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.end_of_file <= eof;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    deframe_byte(b, eof);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold until every queued result is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (book_items_due.size() != 0) @(negedge clk);
  endtask

  task automatic send_book(input byte_q_t f, input int pause_at);
    foreach (f[i]) begin
      send_byte(f[i], i == f.size() - 1);
      if (i == pause_at) wait_drained();
    end
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
    wait_drained();
    repeat (DRAIN_TAIL) @(negedge clk);
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    if (idx == REG_FORMAT_VER) begin
      fmt_reg = val;
    end else begin
      eng_reg = val;
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic void compare_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      failures++;
    end
  endfunction

  // Register defaults, with a record at the field extremes
  task automatic test_reset_defaults();
    byte_q_t f;
    make_book(f, BOOK_GOOD, 0, '0, 1'b0);
    send_book(f, -1);
    make_book(f, BOOK_GOOD, 1, {16'h8000, 16'h7FFF, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF},
              1'b1);
    send_book(f, -1);
  endtask

  // Files that end inside the header
  task automatic test_short_files();
    byte_q_t f;
    f = {8'h47};
    send_book(f, -1);
    make_book(f, BOOK_GOOD, 0, '0, 1'b0);
    void'(f.pop_back());
    send_book(f, -1);
  endtask

  // One fault at a time, then pairs to check precedence
  task automatic test_header_faults();
    byte_q_t f;
    make_book(f, BOOK_BAD_MAGIC, 1, '0, 1'b0);  // record still comes out
    send_book(f, -1);
    make_book(f, BOOK_BAD_FORMAT, 0, '0, 1'b0);
    send_book(f, -1);
    make_book(f, BOOK_BAD_ENGINE, 0, '0, 1'b0);
    send_book(f, -1);
    make_book(f, BOOK_BAD_COUNT, 0, '0, 1'b0);
    send_book(f, -1);
    make_book(f, BOOK_BAD_CRC, 0, '0, 1'b0);
    send_book(f, -1);
    make_book(f, BOOK_PARTIAL, 0, '0, 1'b0);
    send_book(f, -1);
    // magic beats version
    make_book(f, BOOK_BAD_FORMAT, 0, '0, 1'b0);
    f[1] = f[1] ^ 8'h10;
    send_book(f, -1);
    // version beats size
    make_book(f, BOOK_BAD_COUNT, 0, '0, 1'b0);
    f[8] = f[8] ^ 8'h01;
    send_book(f, -1);
    // size beats crc
    make_book(f, BOOK_BAD_COUNT, 0, '0, 1'b0);
    f[16] = f[16] ^ 8'h01;
    send_book(f, -1);
  endtask

  task automatic test_register_extremes();
    byte_q_t f;
    write_reg(REG_FORMAT_VER, 32'h0);
    write_reg(REG_ENGINE_VER, 32'hFFFF_FFFF);
    make_book(f, BOOK_GOOD, 0, '0, 1'b0);
    send_book(f, -1);
    make_book(f, BOOK_BAD_ENGINE, 0, '0, 1'b0);
    send_book(f, -1);
    write_reg(REG_FORMAT_VER, 32'hFFFF_FFFF);
    write_reg(REG_ENGINE_VER, 32'h0);
    make_book(f, BOOK_GOOD, 0, '0, 1'b0);
    send_book(f, -1);
    make_book(f, BOOK_BAD_FORMAT, 0, '0, 1'b0);
    send_book(f, -1);
    write_reg(REG_FORMAT_VER, FORMAT_VER_RST);
    write_reg(REG_ENGINE_VER, ENGINE_VER_RST);
  endtask

  // Sender stops mid-file until the first record is out; that record holds
  // the opposite field extremes
  task automatic test_drain_pause();
    byte_q_t f;
    make_book(f, BOOK_GOOD, 2, {16'h7FFF, 16'h8000, 32'h7FFF_FFFF, 64'h0}, 1'b1);
    send_book(f, HDR_LEN + REC_BYTES - 1);
  endtask

  // Mostly well-formed files with random content, fresh registers every few files
  task automatic test_random_books();
    byte_q_t     f;
    book_shape_t shape;
    int          phase_left;
    int          pick;
    int          n_rec;
    int          bytes_at_start;
    phase_left     = 0;
    bytes_at_start = bytes_sent;
    while (bytes_sent - bytes_at_start < RAND_BYTES) begin
      if (phase_left == 0) begin
        write_reg(REG_FORMAT_VER, pick_version());
        write_reg(REG_ENGINE_VER, pick_version());
        phase_left = $urandom_range(3, 8);
      end
      phase_left--;
      calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 55) shape = BOOK_GOOD;
      else if (pick < 61) shape = BOOK_BAD_MAGIC;
      else if (pick < 66) shape = BOOK_BAD_FORMAT;
      else if (pick < 71) shape = BOOK_BAD_ENGINE;
      else if (pick < 77) shape = BOOK_BAD_COUNT;
      else if (pick < 83) shape = BOOK_BAD_CRC;
      else if (pick < 89) shape = BOOK_PARTIAL;
      else if (pick < 94) shape = BOOK_TRUNCATED;
      else shape = BOOK_NOISE;
      n_rec = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
      make_book(f, shape, n_rec, '0, 1'b0);
      send_book(f, -1);
    end
    calm = 1'b0;
  endtask

  // Result side: random stalls, each item checked against the oldest expectation
  initial begin : result_sink
    int       stall;
    bfd_res_t due;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = pick_wait();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
      if (book_items_due.size() == 0) begin
        $error("result with nothing expected: kind %0b status %0d", out_ch.kind,
               out_ch.status);
        failures++;
      end else begin
        due = book_items_due.pop_front();
        compare_field("kind", due.kind, out_ch.kind);
        compare_field("record_key", due.key, out_ch.record_key);
        compare_field("record_score", due.score, out_ch.record_score);
        compare_field("record_mate", due.mate, out_ch.record_mate);
        compare_field("record_depth", due.depth, out_ch.record_depth);
        compare_field("status", due.status, out_ch.status);
        compare_field("final_res", due.final_res, out_ch.final_res);
      end
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL book_file_record_deframer");
    $finish;
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = 8'h00;
    in_ch.end_of_file = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.addr       = REG_FORMAT_VER;
    cfg_ch.data       = 32'h0;
    fmt_reg           = FORMAT_VER_RST;
    eng_reg           = ENGINE_VER_RST;
    clear_book_state();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_short_files();
    test_header_faults();
    test_register_extremes();
    test_drain_pause();
    test_random_books();

    wait_drained();
    repeat (DRAIN_TAIL) @(negedge clk);
    if (failures == 0 && book_items_due.size() == 0) begin
      $display("PASS book_file_record_deframer");
    end else begin
      $display("FAIL book_file_record_deframer");
    end
    $finish;
  end

endmodule
